FILE: rtl/core/hcpu_pkg.sv
package hcpu_pkg;

  localparam int WORD_W = 16;
  localparam int PC_W   = 15;

  // Destination bits of a C-instruction
  localparam int DEST_M = 0;
  localparam int DEST_D = 1;
  localparam int DEST_A = 2;

  // Jump condition bits of a C-instruction
  localparam int JMP_GT = 0;
  localparam int JMP_EQ = 1;
  localparam int JMP_LT = 2;

  typedef struct packed {
    logic            is_c;
    logic            use_m;
    logic [PC_W-1:0] imm;
    logic [5:0]      comp;
    logic [2:0]      dest;
    logic [2:0]      jump;
  } item_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic signed [WORD_W-1:0] alu_result;
    logic signed [WORD_W-1:0] a_value;
    logic signed [WORD_W-1:0] d_value;
    logic                     halted;
  } result_t;

  function automatic item_t decode(input logic [WORD_W-1:0] word);
    item_t it;
    it.is_c  = word[15];
    it.use_m = word[15] & word[12];
    it.imm   = word[PC_W-1:0];
    it.comp  = word[11:6];
    it.dest  = word[5:3];
    it.jump  = word[2:0];
    return it;
  endfunction

  function automatic logic [WORD_W-1:0] alu(input logic [WORD_W-1:0] x,
                                            input logic [WORD_W-1:0] y,
                                            input logic [5:0]        c);
    logic [WORD_W-1:0] xv;
    logic [WORD_W-1:0] yv;
    logic [WORD_W-1:0] r;
    xv = c[5] ? '0 : x;
    if (c[4]) xv = ~xv;
    yv = c[3] ? '0 : y;
    if (c[2]) yv = ~yv;
    r = c[1] ? (xv + yv) : (xv & yv);
    if (c[0]) r = ~r;
    return r;
  endfunction

endpackage

FILE: rtl/core/hcpu_ram.sv
module hcpu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/hcpu_front.sv
module hcpu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            hold,
  input  logic            in_push,
  output logic            in_full,
  input  logic [15:0]     in_instruction,
  output logic            q_valid,
  output hcpu_pkg::item_t q_item,
  input  logic            q_pop
);
  import hcpu_pkg::*;

  item_t      ent_r [2];
  logic       rd_ptr_r;
  logic       wr_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign in_full = hold | (cnt_r == 2'd2);
  assign push    = in_push & ~in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_pop & q_valid;
  assign q_item  = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // classify on the way in
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= decode(in_instruction);
    end
  end

endmodule

FILE: rtl/core/hcpu_back.sv
module hcpu_back #(
  parameter int DATA_DEPTH = 32768
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [14:0]                   halt_pc,
  input  logic                          q_valid,
  input  hcpu_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          mem_re,
  output logic [$clog2(DATA_DEPTH)-1:0] mem_raddr,
  input  logic [15:0]                   mem_rdata,
  output logic                          mem_we,
  output logic [$clog2(DATA_DEPTH)-1:0] mem_waddr,
  output logic [15:0]                   mem_wdata,
  output logic                          out_empty,
  input  logic                          out_pop,
  output hcpu_pkg::result_t             out_res
);
  import hcpu_pkg::*;

  localparam int ADDR_W = $clog2(DATA_DEPTH);
  localparam logic S_RUN = 1'b0;
  localparam logic S_MEM = 1'b1;

  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] d_r;
  logic [PC_W-1:0]   pc_r;
  logic              st_r;
  logic              st_nxt;
  item_t             cur_r;

  result_t           oq_r [2];
  logic              oq_rd_r;
  logic              oq_wr_r;
  logic [1:0]        oq_cnt_r;
  logic              oq_full;
  logic              oq_pop;

  logic [WORD_W-1:0] addr_ext;
  logic [ADDR_W-1:0] idx;
  item_t             ex_item;
  logic [WORD_W-1:0] y;
  logic              exec_en;
  logic [WORD_W-1:0] res;
  logic              neg;
  logic              zero;
  logic              take;
  logic [PC_W-1:0]   next_pc;
  logic [WORD_W-1:0] a_nxt;
  logic [WORD_W-1:0] d_nxt;
  logic              halted;

  // address is the low 15 bits of A wrapped into the memory depth
  always_comb begin
    addr_ext = {1'b0, a_r[PC_W-1:0]};
    if (addr_ext >= WORD_W'(DATA_DEPTH)) addr_ext = addr_ext - WORD_W'(DATA_DEPTH);
    idx = addr_ext[ADDR_W-1:0];
  end

  assign oq_full = (oq_cnt_r == 2'd2);

  always_comb begin
    q_pop   = 1'b0;
    mem_re  = 1'b0;
    exec_en = 1'b0;
    st_nxt  = st_r;
    ex_item = q_item;
    y       = a_r;
    case (st_r)
      S_RUN: begin
        if (q_valid) begin
          if (q_item.use_m) begin
            // fetch M first, execute from S_MEM once the result queue has room
            mem_re = 1'b1;
            q_pop  = 1'b1;
            st_nxt = S_MEM;
          end else if (!oq_full) begin
            exec_en = 1'b1;
            q_pop   = 1'b1;
          end
        end
      end
      S_MEM: begin
        ex_item = cur_r;
        y       = mem_rdata;
        if (!oq_full) begin
          exec_en = 1'b1;
          st_nxt  = S_RUN;
        end
      end
      default: st_nxt = S_RUN;
    endcase
  end

  always_comb begin
    res     = ex_item.is_c ? alu(d_r, y, ex_item.comp) : '0;
    neg     = res[WORD_W-1];
    zero    = (res == '0);
    take    = (ex_item.jump[JMP_LT] & neg) | (ex_item.jump[JMP_EQ] & zero) |
              (ex_item.jump[JMP_GT] & ~neg & ~zero);
    next_pc = pc_r + PC_W'(1);
    a_nxt   = a_r;
    d_nxt   = d_r;
    halted  = 1'b0;
    if (!ex_item.is_c) begin
      a_nxt = {1'b0, ex_item.imm};
    end else begin
      if (take) next_pc = a_r[PC_W-1:0];
      if (ex_item.dest[DEST_D]) d_nxt = res;
      if (ex_item.dest[DEST_A]) a_nxt = res;
      halted = (next_pc == halt_pc);
    end
  end

  assign mem_raddr = idx;
  assign mem_we    = exec_en & ex_item.is_c & ex_item.dest[DEST_M];
  assign mem_waddr = idx;
  assign mem_wdata = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r  <= '0;
      d_r  <= '0;
      pc_r <= '0;
      st_r <= S_RUN;
    end else begin
      st_r <= st_nxt;
      if (exec_en) begin
        a_r  <= a_nxt;
        d_r  <= d_nxt;
        pc_r <= next_pc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) cur_r <= q_item;
  end

  // result queue
  assign out_empty = (oq_cnt_r == 2'd0);
  assign oq_pop    = out_pop & ~out_empty;
  assign out_res   = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_rd_r  <= 1'b0;
      oq_wr_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (exec_en) oq_wr_r <= ~oq_wr_r;
      if (oq_pop) oq_rd_r <= ~oq_rd_r;
      oq_cnt_r <= oq_cnt_r + {1'b0, exec_en} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      oq_r[oq_wr_r].next_pc    <= next_pc;
      oq_r[oq_wr_r].alu_result <= res;
      oq_r[oq_wr_r].a_value    <= a_nxt;
      oq_r[oq_wr_r].d_value    <= d_nxt;
      oq_r[oq_wr_r].halted     <= halted;
    end
  end

endmodule

FILE: rtl/core/hack_cpu_instruction_step_unit.sv
// Hack CPU instruction step unit.
// Input queue side: drive in_instruction with the word fetched at the current
// program counter and raise in_push; the word is taken when in_full is low.
// Result queue side: while out_empty is low the oldest result (next pc, ALU
// output, A, D, halted) is on the out_ ports; raise out_pop to take it.
// Config: cfg_halt_pc is written when cfg_valid and cfg_ready are high;
// cfg_ready is always high. Write it only while the unit is idle.
// Path: a request passes the input queue register, then the result queue
// register; one that reads M also passes the registered data RAM read.
// Throughput: one request per cycle while the result queue has room, except a
// C-instruction reading M, which waits in S_MEM for the registered RAM read.
// Reset: A, D and pc clear, both queues empty, and the data RAM is swept to
// zero one word per cycle across all DATA_DEPTH words, with in_full held high.
// If the result side stalls, two results wait in the result queue and two
// requests in the input queue before in_full rises.
module hack_cpu_instruction_step_unit #(
  parameter int DATA_DEPTH = 32768
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [15:0]        in_instruction,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [14:0]        out_next_pc,
  output logic signed [15:0] out_alu_result,
  output logic signed [15:0] out_a_value,
  output logic signed [15:0] out_d_value,
  output logic               out_halted,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_halt_pc
);
  import hcpu_pkg::*;

  localparam int ADDR_W = $clog2(DATA_DEPTH);

  logic [PC_W-1:0]   halt_pc_r;
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  result_t           out_res;

  logic              be_re;
  logic [ADDR_W-1:0] be_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              be_we;
  logic [ADDR_W-1:0] be_waddr;
  logic [WORD_W-1:0] be_wdata;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_pc_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      halt_pc_r <= cfg_halt_pc;
    end
  end

  // sweep the data RAM to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DATA_DEPTH - 1)) clr_active_r <= 1'b0;
    end
  end

  assign ram_we    = clr_active_r | be_we;
  assign ram_waddr = clr_active_r ? clr_addr_r : be_waddr;
  assign ram_wdata = clr_active_r ? '0 : be_wdata;

  hcpu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold           (clr_active_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_instruction (in_instruction),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  hcpu_back #(
    .DATA_DEPTH (DATA_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .halt_pc   (halt_pc_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .mem_re    (be_re),
    .mem_raddr (be_raddr),
    .mem_rdata (ram_rdata),
    .mem_we    (be_we),
    .mem_waddr (be_waddr),
    .mem_wdata (be_wdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  hcpu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DATA_DEPTH)
  ) u_dmem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (be_re),
    .raddr (be_raddr),
    .rdata (ram_rdata)
  );

  assign out_next_pc    = out_res.next_pc;
  assign out_alu_result = out_res.alu_result;
  assign out_a_value    = out_res.a_value;
  assign out_d_value    = out_res.d_value;
  assign out_halted     = out_res.halted;

endmodule

FILE: rtl/core/hcpu_checker.sv
module hcpu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic [15:0]        in_instruction,
  input logic               out_empty,
  input logic               out_pop,
  input logic [14:0]        out_next_pc,
  input logic signed [15:0] out_alu_result,
  input logic signed [15:0] out_a_value,
  input logic signed [15:0] out_d_value,
  input logic               out_halted,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [14:0]        cfg_halt_pc
);

  logic [14:0] hp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      hp_r <= cfg_halt_pc;
    end
  end

  // reset starts the RAM sweep, so no request may enter
  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("in_full low right after reset");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // a halted result must point at the halt address
  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_halted) |-> (out_next_pc == hp_r))
    else $error("halted with next pc not at halt address");

  // hold the head result until it is popped
  a_hold_head: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_next_pc) &&
                                  $stable(out_a_value) && $stable(out_d_value)))
    else $error("waiting result changed before pop");

endmodule

bind hack_cpu_instruction_step_unit hcpu_checker u_hcpu_checker (.*);
